// ----- hw/rtl/json_string_unescaper_assert.svh -----
// Assertion macros for the checker file of the string unescaper.
`ifndef JSON_STRING_UNESCAPER_ASSERT_SVH
`define JSON_STRING_UNESCAPER_ASSERT_SVH

// Check a property on every clock edge out of reset.
`define JSU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define JSU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- hw/rtl/jsu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// Types and constants of the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // Decoder modes
  typedef enum logic [3:0] {
    MODE_PLAIN = 4'd0,
    MODE_ESC   = 4'd1,
    MODE_HI0   = 4'd2,
    MODE_HI1   = 4'd3,
    MODE_HI2   = 4'd4,
    MODE_HI3   = 4'd5,
    MODE_BSL   = 4'd6,
    MODE_LU    = 4'd7,
    MODE_LO0   = 4'd8,
    MODE_LO1   = 4'd9,
    MODE_LO2   = 4'd10,
    MODE_LO3   = 4'd11
  } mode_e;

  // Error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_ESCAPE  = 2'd1;
  localparam logic [1:0] ERR_ENCODE  = 2'd2;
  localparam logic [1:0] ERR_ILLEGAL = 2'd3;

  // Characters
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Surrogate prefixes (top six bits of a UTF-16 unit)
  localparam logic [5:0] SURR_HIGH = 6'b110110;
  localparam logic [5:0] SURR_LOW  = 6'b110111;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  localparam int unsigned MAX_RES = 4;
  localparam int unsigned CNT_W   = $clog2(MAX_RES + 1);

  // One result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic       string_done;
    logic       key_flag;
    logic [1:0] err_code;
  } res_t;

  // All results of one input byte, slot 0 first
  typedef struct packed {
    logic [CNT_W-1:0]       count;
    res_t [MAX_RES-1:0]     slot;
  } burst_t;

endpackage

// ----- hw/rtl/jsu_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_in_if
// Input byte channel of the JSON string unescaper.
// ----------------------------------------------------------------------------
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_key;

  modport source (output valid, output in_byte, output is_key, input ready);
  modport sink   (input valid, input in_byte, input is_key, output ready);
  modport monitor (input valid, input in_byte, input is_key, input ready);
endinterface

// ----- hw/rtl/jsu_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_out_if
// Result channel of the JSON string unescaper.
// ----------------------------------------------------------------------------
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       last;
  logic       string_done;
  logic       key_flag;
  logic [1:0] err_code;

  modport source (output valid, output out_byte, output byte_valid, output last,
                  output string_done, output key_flag, output err_code,
                  input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input last,
                  input string_done, input key_flag, input err_code,
                  output ready);
  modport monitor (input valid, input out_byte, input byte_valid, input last,
                   input string_done, input key_flag, input err_code,
                   input ready);
endinterface

// ----- hw/rtl/json_string_unescaper.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescaper
// Decodes a JSON string body byte by byte into UTF-8 with end and error marks.
// ----------------------------------------------------------------------------
//   channel  dir  carries
//   in_i     in   in_byte, is_key        raw byte after the opening quote
//   out_o    out  out_byte, byte_valid,  one decoded byte, end or error mark
//                 last, string_done,
//                 key_flag, err_code
//
// One byte per cycle is taken while in_i.ready is high; a byte that yields
// several results holds in_i.ready low until its last result leaves, as the
// result register hands out one result per transfer (up to four results for UTF-8).
// The first result is offered in the cycle after the input transfer.
// Reset clears the mode and empties the result register; no clearing pass.
// A stall on out_o holds the pending result and blocks input while any waits.
// ----------------------------------------------------------------------------
module json_string_unescaper (
  input  logic   clk_i,
  input  logic   rst_ni,
  jsu_in_if.sink    in_i,
  jsu_out_if.source out_o
);

  jsu_pkg::burst_t burst;
  jsu_pkg::res_t   res;
  logic            accept;
  logic            in_ready;

  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;

  jsu_decoder u_decoder (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_i.in_byte),
    .is_key_i  (in_i.is_key),
    .burst_o   (burst)
  );

  jsu_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .burst_i     (burst),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_res_o   (res),
    .in_ready_o  (in_ready)
  );

  // Drive the result fields.
  assign out_o.out_byte    = res.out_byte;
  assign out_o.byte_valid  = res.byte_valid;
  assign out_o.last        = res.last;
  assign out_o.string_done = res.string_done;
  assign out_o.key_flag    = res.key_flag;
  assign out_o.err_code    = res.err_code;

endmodule

// ----- hw/rtl/jsu_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_decoder
// Escape state machine and UTF-8 encoder: turns one raw byte into a burst.
// ----------------------------------------------------------------------------
module jsu_decoder (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      in_byte_i,
  input  logic            is_key_i,
  output jsu_pkg::burst_t burst_o
);

  jsu_pkg::mode_e mode_q, mode_d;
  logic [15:0]    hi_q, hi_d;
  logic [15:0]    lo_q, lo_d;
  logic [4:0]     hex;
  logic [15:0]    hi_new;
  logic [15:0]    lo_new;
  logic [20:0]    pair_cp;
  logic           hi_surr;
  logic           lo_surr;
  logic           esc_ok;
  logic [7:0]     esc_byte;

  // Build a result that carries a decoded byte.
  function automatic jsu_pkg::res_t mk_byte(input logic [7:0] b, input logic lst);
    jsu_pkg::res_t r;
    r             = '0;
    r.out_byte    = b;
    r.byte_valid  = 1'b1;
    r.last        = lst;
    return r;
  endfunction

  // Build a burst of one complete byte.
  function automatic jsu_pkg::burst_t one_byte(input logic [7:0] b);
    jsu_pkg::burst_t bu;
    bu         = '0;
    bu.count   = jsu_pkg::CNT_W'(1);
    bu.slot[0] = mk_byte(b, 1'b1);
    return bu;
  endfunction

  // Build an error result.
  function automatic jsu_pkg::burst_t mk_err(input logic [1:0] code);
    jsu_pkg::burst_t bu;
    bu                  = '0;
    bu.count            = jsu_pkg::CNT_W'(1);
    bu.slot[0].last     = 1'b1;
    bu.slot[0].err_code = code;
    return bu;
  endfunction

  // Decode a hex digit; bit 4 flags a non-hex character.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b0, c[3:0] + 4'd9};
    end else begin
      r = 5'h10;
    end
    return r;
  endfunction

  // Encode a code point as one to four UTF-8 bytes.
  function automatic jsu_pkg::burst_t enc_cp(input logic [20:0] cp);
    jsu_pkg::burst_t bu;
    bu = '0;
    if (cp < 21'h80) begin
      bu.count   = jsu_pkg::CNT_W'(1);
      bu.slot[0] = mk_byte(cp[7:0], 1'b1);
    end else if (cp < 21'h800) begin
      bu.count   = jsu_pkg::CNT_W'(2);
      bu.slot[0] = mk_byte({3'b110, cp[10:6]}, 1'b0);
      bu.slot[1] = mk_byte({2'b10, cp[5:0]}, 1'b1);
    end else if (cp < jsu_pkg::SUPP_BASE) begin
      bu.count   = jsu_pkg::CNT_W'(3);
      bu.slot[0] = mk_byte({4'b1110, cp[15:12]}, 1'b0);
      bu.slot[1] = mk_byte({2'b10, cp[11:6]}, 1'b0);
      bu.slot[2] = mk_byte({2'b10, cp[5:0]}, 1'b1);
    end else begin
      bu.count   = jsu_pkg::CNT_W'(4);
      bu.slot[0] = mk_byte({5'b11110, cp[20:18]}, 1'b0);
      bu.slot[1] = mk_byte({2'b10, cp[17:12]}, 1'b0);
      bu.slot[2] = mk_byte({2'b10, cp[11:6]}, 1'b0);
      bu.slot[3] = mk_byte({2'b10, cp[5:0]}, 1'b1);
    end
    return bu;
  endfunction

  // Shift the new digit into the units and combine a surrogate pair.
  assign hex     = hex_digit(in_byte_i);
  assign hi_new  = {hi_q[11:0], hex[3:0]};
  assign lo_new  = {lo_q[11:0], hex[3:0]};
  assign hi_surr = (hi_new[15:10] == jsu_pkg::SURR_HIGH);
  assign lo_surr = (lo_new[15:10] == jsu_pkg::SURR_LOW);
  assign pair_cp = jsu_pkg::SUPP_BASE + {1'b0, hi_q[9:0], lo_new[9:0]};

  // Map a single-letter escape to its byte.
  always_comb begin
    esc_ok   = 1'b1;
    esc_byte = in_byte_i;
    unique case (in_byte_i)
      jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: esc_byte = in_byte_i;
      jsu_pkg::CH_B: esc_byte = 8'h08;
      jsu_pkg::CH_F: esc_byte = 8'h0C;
      jsu_pkg::CH_N: esc_byte = 8'h0A;
      jsu_pkg::CH_R: esc_byte = 8'h0D;
      jsu_pkg::CH_T: esc_byte = 8'h09;
      default:       esc_ok   = 1'b0;
    endcase
  end

  // Next mode and units for the current byte.
  always_comb begin
    mode_d = mode_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    unique case (mode_q) inside
      jsu_pkg::MODE_ESC: begin
        if (in_byte_i == jsu_pkg::CH_U) begin
          hi_d   = '0;
          mode_d = jsu_pkg::MODE_HI0;
        end else begin
          mode_d = jsu_pkg::MODE_PLAIN;
          if (!esc_ok) begin
            hi_d = '0;
            lo_d = '0;
          end
        end
      end
      jsu_pkg::MODE_HI0, jsu_pkg::MODE_HI1, jsu_pkg::MODE_HI2, jsu_pkg::MODE_HI3: begin
        if (hex[4]) begin
          mode_d = jsu_pkg::MODE_PLAIN;
          hi_d   = '0;
          lo_d   = '0;
        end else begin
          hi_d = hi_new;
          if (mode_q != jsu_pkg::MODE_HI3) begin
            mode_d = jsu_pkg::mode_e'(mode_q + 4'd1);
          end else if (hi_surr) begin
            mode_d = jsu_pkg::MODE_BSL;
          end else begin
            mode_d = jsu_pkg::MODE_PLAIN;
          end
        end
      end
      jsu_pkg::MODE_BSL: begin
        if (in_byte_i != jsu_pkg::CH_BSLASH) begin
          mode_d = jsu_pkg::MODE_PLAIN;
          hi_d   = '0;
          lo_d   = '0;
        end else begin
          mode_d = jsu_pkg::MODE_LU;
        end
      end
      jsu_pkg::MODE_LU: begin
        if (in_byte_i != jsu_pkg::CH_U) begin
          mode_d = jsu_pkg::MODE_PLAIN;
          hi_d   = '0;
          lo_d   = '0;
        end else begin
          lo_d   = '0;
          mode_d = jsu_pkg::MODE_LO0;
        end
      end
      jsu_pkg::MODE_LO0, jsu_pkg::MODE_LO1, jsu_pkg::MODE_LO2, jsu_pkg::MODE_LO3: begin
        if (hex[4] || (mode_q == jsu_pkg::MODE_LO3 && !lo_surr)) begin
          mode_d = jsu_pkg::MODE_PLAIN;
          hi_d   = '0;
          lo_d   = '0;
        end else if (mode_q != jsu_pkg::MODE_LO3) begin
          lo_d   = lo_new;
          mode_d = jsu_pkg::mode_e'(mode_q + 4'd1);
        end else begin
          lo_d   = lo_new;
          mode_d = jsu_pkg::MODE_PLAIN;
        end
      end
      default: begin
        // plain text and the unused mode codes
        mode_d = jsu_pkg::MODE_PLAIN;
        if (in_byte_i == jsu_pkg::CH_QUOTE || in_byte_i < jsu_pkg::CH_SPACE) begin
          hi_d = '0;
          lo_d = '0;
        end else if (in_byte_i == jsu_pkg::CH_BSLASH) begin
          mode_d = jsu_pkg::MODE_ESC;
        end
      end
    endcase
  end

  // Results of the current byte.
  always_comb begin
    burst_o = '0;
    unique case (mode_q) inside
      jsu_pkg::MODE_ESC: begin
        if (esc_ok) begin
          burst_o = one_byte(esc_byte);
        end else if (in_byte_i != jsu_pkg::CH_U) begin
          burst_o = mk_err(jsu_pkg::ERR_ESCAPE);
        end
      end
      jsu_pkg::MODE_HI0, jsu_pkg::MODE_HI1, jsu_pkg::MODE_HI2, jsu_pkg::MODE_HI3: begin
        if (hex[4]) begin
          burst_o = mk_err(jsu_pkg::ERR_ENCODE);
        end else if (mode_q == jsu_pkg::MODE_HI3 && !hi_surr) begin
          burst_o = enc_cp({5'd0, hi_new});
        end
      end
      jsu_pkg::MODE_BSL: begin
        if (in_byte_i != jsu_pkg::CH_BSLASH) begin
          burst_o = mk_err(jsu_pkg::ERR_ENCODE);
        end
      end
      jsu_pkg::MODE_LU: begin
        if (in_byte_i != jsu_pkg::CH_U) begin
          burst_o = mk_err(jsu_pkg::ERR_ENCODE);
        end
      end
      jsu_pkg::MODE_LO0, jsu_pkg::MODE_LO1, jsu_pkg::MODE_LO2, jsu_pkg::MODE_LO3: begin
        if (hex[4]) begin
          burst_o = mk_err(jsu_pkg::ERR_ENCODE);
        end else if (mode_q == jsu_pkg::MODE_LO3) begin
          burst_o = lo_surr ? enc_cp(pair_cp) : mk_err(jsu_pkg::ERR_ENCODE);
        end
      end
      default: begin
        // plain text and the unused mode codes
        if (in_byte_i == jsu_pkg::CH_QUOTE) begin
          burst_o.count               = jsu_pkg::CNT_W'(1);
          burst_o.slot[0].last        = 1'b1;
          burst_o.slot[0].string_done = 1'b1;
          burst_o.slot[0].key_flag    = is_key_i;
        end else if (in_byte_i < jsu_pkg::CH_SPACE) begin
          burst_o = mk_err(jsu_pkg::ERR_ILLEGAL);
        end else if (in_byte_i != jsu_pkg::CH_BSLASH) begin
          burst_o = one_byte(in_byte_i);
        end
      end
    endcase
  end

  // Advance the mode and units on each transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= jsu_pkg::MODE_PLAIN;
      hi_q   <= '0;
      lo_q   <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      hi_q   <= hi_d;
      lo_q   <= lo_d;
    end
  end

endmodule

// ----- hw/rtl/jsu_emitter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_emitter
// Result register: holds one burst and hands it out one result per transfer.
// ----------------------------------------------------------------------------
module jsu_emitter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  jsu_pkg::burst_t burst_i,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output jsu_pkg::res_t   out_res_o,
  output logic            in_ready_o
);

  logic [jsu_pkg::CNT_W-1:0]         cnt_q, cnt_d;
  jsu_pkg::res_t [jsu_pkg::MAX_RES-1:0] slot_q, slot_d;
  logic                              pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_res_o   = slot_q[0];
  assign pop         = out_valid_o && out_ready_i;

  // Take a new burst when empty or once the last pending result leaves this cycle.
  assign in_ready_o = (cnt_q == '0) || ((cnt_q == jsu_pkg::CNT_W'(1)) && out_ready_i);

  // Load a burst or shift the pending results down.
  always_comb begin
    cnt_d  = cnt_q;
    slot_d = slot_q;
    if (load_i) begin
      cnt_d  = burst_i.count;
      slot_d = burst_i.slot;
    end else if (pop) begin
      cnt_d = cnt_q - jsu_pkg::CNT_W'(1);
      for (int i = 0; i < jsu_pkg::MAX_RES - 1; i++) begin
        slot_d[i] = slot_q[i+1];
      end
      slot_d[jsu_pkg::MAX_RES-1] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Hold payload without reset.
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

// ----- hw/rtl/jsu_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level assertions for the JSON string unescaper, bound to the top.
// ----------------------------------------------------------------------------
`include "json_string_unescaper_assert.svh"

module jsu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_bvalid_i,
  input logic        out_last_i,
  input logic [13:0] out_data_i
);

  // A stalled result stays offered.
  `JSU_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped")

  // A stalled result keeps its payload.
  `JSU_ASSERT(a_out_stable, out_valid_i && !out_ready_i |=> $stable(out_data_i), "payload moved")

  // A new byte enters only as the final result of a burst leaves.
  `JSU_ASSERT(a_in_gap, in_valid_i && in_ready_i && out_valid_i |-> out_last_i && out_ready_i, "early input")

  // A lead byte of a multibyte sequence is followed by its continuation.
  `JSU_ASSERT(a_burst_cont, out_valid_i && out_ready_i && out_bvalid_i && !out_last_i |=> out_valid_i && out_bvalid_i, "broken sequence")

  // No result is offered during reset.
  `JSU_ASSERT_ALWAYS(a_rst_idle, !rst_ni |-> !out_valid_i, "result offered in reset")

endmodule

bind json_string_unescaper jsu_checker u_jsu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_bvalid_i (out_o.byte_valid),
  .out_last_i   (out_o.last),
  .out_data_i   ({out_o.out_byte, out_o.byte_valid, out_o.last, out_o.string_done,
                  out_o.key_flag, out_o.err_code})
);
